// File: sv/sha1md_pkg.sv
package sha1md_pkg;

    localparam int BLOCK_BITS   = 512;
    localparam int WORDS        = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } request_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } result_t;

    // One full 64-byte block, byte 0 in the top bits; last marks the final block of a message
    typedef struct packed {
        logic                  last;
        logic [BLOCK_BITS-1:0] data;
    } block_t;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_TAB [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_START     = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

// File: sv/sha1md_fifo.sv
module sha1md_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/sha1md_front.sv
module sha1md_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sha1md_pkg::request_t request,
    output logic                full,
    output logic                blk_push,
    output sha1md_pkg::block_t  blk,
    input  logic                blk_full
);

    typedef enum logic [1:0] {F_TAKE, F_MARK, F_ZERO, F_LEN} state_t;

    state_t      state_reg, state_next;
    logic [sha1md_pkg::BLOCK_BITS-1:0] block_reg, block_next, merged;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic        put_en;
    logic [7:0]  put_byte;
    logic        last_blk;

    always_comb
    begin
        state_next   = state_reg;
        bits_next    = bits_reg;
        len_idx_next = len_idx_reg;
        put_en       = 1'b0;
        put_byte     = '0;
        last_blk     = 1'b0;
        unique case (state_reg)
            F_TAKE:
            begin
                if (push && !blk_full)
                begin
                    if (request.byte_valid)
                    begin
                        put_en    = 1'b1;
                        put_byte  = request.data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (request.end_of_message)
                    begin
                        state_next = F_MARK;
                    end
                end
            end
            F_MARK:
            begin
                if (!blk_full)
                begin
                    put_en     = 1'b1;
                    put_byte   = sha1md_pkg::PAD_MARK;
                    state_next = F_ZERO;
                end
            end
            F_ZERO:
            begin
                if (!blk_full)
                begin
                    if (fill_reg == sha1md_pkg::LEN_START)
                    begin
                        state_next = F_LEN;
                    end
                    else
                    begin
                        put_en   = 1'b1;
                        put_byte = 8'h00;
                    end
                end
            end
            F_LEN:
            begin
                if (!blk_full)
                begin
                    // length goes out most significant byte first
                    put_en   = 1'b1;
                    put_byte = bits_reg[{~len_idx_reg, 3'b000} +: 8];
                    if (&len_idx_reg)
                    begin
                        last_blk     = 1'b1;
                        state_next   = F_TAKE;
                        bits_next    = '0;
                        len_idx_next = '0;
                    end
                    else
                    begin
                        len_idx_next = len_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_comb
    begin
        merged = block_reg;
        for (int j = 0; j < 64; j++)
        begin
            if (6'(j) == fill_reg)
            begin
                merged[sha1md_pkg::BLOCK_BITS - 1 - 8 * j -: 8] = put_byte;
            end
        end
        block_next = put_en ? merged : block_reg;
        fill_next  = put_en ? fill_reg + 6'd1 : fill_reg;
    end

    // Hand the block over on its last byte; fill wraps back to zero
    assign blk_push = put_en && (&fill_reg);
    assign blk.last = last_blk;
    assign blk.data = merged;
    assign full     = (state_reg != F_TAKE) || blk_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_TAKE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            len_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            len_idx_reg <= len_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

endmodule

// File: sv/sha1md_back.sv
module sha1md_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blk_empty,
    input  sha1md_pkg::block_t blk,
    output logic               blk_pop,
    input  logic               res_full,
    output logic               res_push,
    output sha1md_pkg::result_t res
);

    typedef enum logic [1:0] {B_IDLE, B_ROUND, B_FOLD, B_EMIT} state_t;

    state_t      state_reg, state_next;
    logic [31:0] h_reg [sha1md_pkg::DIGEST_WORDS];
    logic [31:0] h_next [sha1md_pkg::DIGEST_WORDS];
    logic [31:0] w_reg [sha1md_pkg::WORDS];
    logic [31:0] w_next [sha1md_pkg::WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [6:0]  t_reg, t_next;
    logic        last_reg, last_next;
    logic [2:0]  word_reg, word_next;
    logic [31:0] f_val, k_val, w_mix, w_new, temp;

    // Round function and constant by round group
    always_comb
    begin
        if (t_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K_TAB[0];
        end
        else if (t_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_TAB[1];
        end
        else if (t_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K_TAB[2];
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_TAB[3];
        end
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        temp  = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    end

    assign blk_pop         = (state_reg == B_IDLE) && !blk_empty;
    assign res_push        = (state_reg == B_EMIT) && !res_full;
    assign res.digest_word = h_reg[word_reg];
    assign res.word_number = word_reg;
    assign res.last_word   = (word_reg == sha1md_pkg::LAST_WORD_IDX);

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        t_next     = t_reg;
        last_next  = last_reg;
        word_next  = word_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!blk_empty)
                begin
                    for (int i = 0; i < sha1md_pkg::WORDS; i++)
                    begin
                        w_next[i] = blk.data[sha1md_pkg::BLOCK_BITS - 1 - 32 * i -: 32];
                    end
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                    last_next  = blk.last;
                    t_next     = '0;
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                // advance the schedule window by one word
                for (int i = 0; i < sha1md_pkg::WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[sha1md_pkg::WORDS - 1] = w_new;
                e_next = d_reg;
                d_next = c_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                b_next = a_reg;
                a_next = temp;
                t_next = t_reg + 7'd1;
                if (t_reg == 7'(sha1md_pkg::ROUNDS - 1))
                begin
                    state_next = B_FOLD;
                end
            end
            B_FOLD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                word_next  = '0;
                state_next = last_reg ? B_EMIT : B_IDLE;
            end
            B_EMIT:
            begin
                if (!res_full)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == sha1md_pkg::LAST_WORD_IDX)
                    begin
                        // restart chaining for the next message
                        h_next     = sha1md_pkg::H_INIT;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            h_reg     <= sha1md_pkg::H_INIT;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
            t_reg     <= '0;
            last_reg  <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            t_reg     <= t_next;
            last_reg  <= last_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

endmodule

// File: sv/sha1_message_digest.sv
// SHA-1 digest engine, fed one message byte per request.
// Input queue side: present a request and raise push; it is taken on an edge where
// full is low. byte_valid low carries no byte; end_of_message closes the message
// (with or without a byte), so an empty message is a single request.
// Result queue side: while empty is low the oldest digest word sits on result;
// pop takes it. Each message yields five words, h0 first, last_word on word 4.
// Bytes are packed into 64-byte blocks at one request per cycle while full is low. A full
// block goes through a block queue (BLOCK_DEPTH entries) to the compression core, which
// works on each block in turn: one load, 80 rounds on a single round unit, one fold.
// The front packs the next block while the core works; once the block queue fills,
// full rises and intake waits on the core. After end_of_message the front pads the
// message (full held high) and the final one or two blocks are compressed; the core
// then writes the digest words to the result queue, one word per cycle while that
// queue is not full. A stalled result side fills the result queue (RESULT_DEPTH
// words); the core then holds, the block queue fills and full rises. Reset drops all
// queued work and restores the initial chaining words.
module sha1_message_digest #(
    parameter int BLOCK_DEPTH  = 2,
    parameter int RESULT_DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  sha1md_pkg::request_t request,
    output logic                 empty,
    input  logic                 pop,
    output sha1md_pkg::result_t  result
);

    sha1md_pkg::block_t  blk_in, blk_out;
    sha1md_pkg::result_t res_in;
    logic                blk_push, blk_full, blk_pop, blk_empty;
    logic                res_push, res_full;

    sha1md_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .blk_push (blk_push),
        .blk      (blk_in),
        .blk_full (blk_full)
    );

    sha1md_fifo #(
        .WIDTH ($bits(sha1md_pkg::block_t)),
        .DEPTH (BLOCK_DEPTH)
    ) u_blk_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (blk_push),
        .wdata (blk_in),
        .full  (blk_full),
        .pop   (blk_pop),
        .rdata (blk_out),
        .empty (blk_empty)
    );

    sha1md_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_empty (blk_empty),
        .blk       (blk_out),
        .blk_pop   (blk_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sha1md_fifo #(
        .WIDTH ($bits(sha1md_pkg::result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: sv/sha1md_checker.sv
module sha1md_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input sha1md_pkg::result_t result
);

    // hold a waiting word until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting digest word changed before pop");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last_word) ##1 !empty
        |-> result.word_number == $past(result.word_number) + 3'd1)
        else $error("digest words out of order");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.last_word) ##1 !empty
        |-> result.word_number == 3'd0)
        else $error("new digest does not start at word 0");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.word_number == 3'd3) ##1 !empty
        |-> result.last_word)
        else $error("fifth word not marked last");

endmodule

bind sha1_message_digest sha1md_checker u_checker (.*);

// File: tb/sv/tb_sha1_message_digest.sv
module tb_sha1_message_digest;

    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT  = 12000;
    localparam int TAIL_CYCLES     = 300;
    localparam int TOTAL_REQUESTS  = 310;

    class sha1_scoreboard;
        logic [31:0] chain [5];
        logic [31:0] block_buf [16];
        int unsigned fill;
        logic [63:0] bit_count;
        sha1md_pkg::result_t digest_q [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0]  = 32'h67452301;
            chain[1]  = 32'hEFCDAB89;
            chain[2]  = 32'h98BADCFE;
            chain[3]  = 32'h10325476;
            chain[4]  = 32'hC3D2E1F0;
            fill      = 0;
            bit_count = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            int i;
            for (i = 0; i < 16; i++)
                w[i] = block_buf[i];
            for (i = 16; i < 80; i++)
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // big-endian packing: byte 0 of each word lands in the top bits
        function void put_byte(logic [7:0] v);
            block_buf[fill >> 2][8 * (3 - (fill & 3)) +: 8] = v;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_request(sha1md_pkg::request_t r);
            logic [63:0] len;
            sha1md_pkg::result_t w;
            int          i;
            if (r.byte_valid)
            begin
                put_byte(r.data_byte);
                bit_count += 64'd8;
            end
            if (!r.end_of_message)
                return;
            len = bit_count;
            put_byte(sha1md_pkg::PAD_MARK);
            // no room for the length: close this block and start another
            if (fill > sha1md_pkg::LEN_START)
                while (fill != 0)
                    put_byte(8'h00);
            while (fill < sha1md_pkg::LEN_START)
                put_byte(8'h00);
            for (i = 7; i >= 0; i--)
                put_byte(len[8*i +: 8]);
            for (i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
            begin
                w.digest_word = chain[i];
                w.word_number = i[2:0];
                w.last_word   = (i[2:0] == sha1md_pkg::LAST_WORD_IDX);
                digest_q.push_back(w);
            end
            restart();
        endfunction

        function void check_word(sha1md_pkg::result_t got);
            sha1md_pkg::result_t exp;
            if (digest_q.size() == 0)
            begin
                $display("%0t: digest word %h (number %0d) with none expected",
                         $time, got.digest_word, got.word_number);
                errors++;
                return;
            end
            exp = digest_q.pop_front();
            if (got.digest_word !== exp.digest_word)
            begin
                $display("%0t: digest_word expected %h got %h",
                         $time, exp.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_number !== exp.word_number)
            begin
                $display("%0t: word_number expected %0d got %0d",
                         $time, exp.word_number, got.word_number);
                errors++;
            end
            if (got.last_word !== exp.last_word)
            begin
                $display("%0t: last_word expected %b got %b",
                         $time, exp.last_word, got.last_word);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    sha1md_pkg::request_t request = '0;
    logic     full;
    logic     empty;
    sha1md_pkg::result_t  result;

    sha1_scoreboard sb = new();
    int requests_sent  = 0;
    int words_seen     = 0;
    int idle_cycles    = 0;

    sha1_message_digest dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // mostly back to back, sometimes a few cycles, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic sha1md_pkg::request_t make_request(logic [7:0] d, logic v, logic eom);
        sha1md_pkg::request_t r;
        r.data_byte      = d;
        r.byte_valid     = v;
        r.end_of_message = eom;
        return r;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input sha1md_pkg::request_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        int  i;
        bit  end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (i = 0; i < len; i++)
        begin
            // stray request carrying no byte
            if ($urandom_range(0, 9) == 0)
                send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_request(make_request(8'($urandom_range(0, 255)), 1'b1,
                                      end_on_byte && (i == len - 1)));
        end
        if (!end_on_byte)
            send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 8);
        else if (r < 78)
            return $urandom_range(9, 54);
        else if (r < 93)
        begin
            // lengths around the padding boundaries
            case ($urandom_range(0, 6))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 60;
                4: return 63;
                5: return 64;
                default: return 65;
            endcase
        end
        return $urandom_range(100, 128);
    endfunction

    initial
    begin : drain
        int hold;
        bit held_off;
        hold     = 0;
        held_off = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            // hold off once for long enough to back the block up into full
            if (!held_off && words_seen >= 20)
            begin
                held_off = 1;
                hold     = HOLD_OFF_CYCLES;
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
                pop <= 1'b1;
            @(posedge clk);
            if (pop && !empty)
            begin
                sb.check_word(result);
                words_seen++;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int len;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // byteless request without end mark: ignored
        send_request(make_request(8'hFF, 1'b0, 1'b0));
        // empty message
        send_request(make_request(8'hA5, 1'b0, 1'b1));
        // "abc", end mark on the last byte
        send_request(make_request(8'h61, 1'b1, 1'b0));
        send_request(make_request(8'h62, 1'b1, 1'b0));
        send_request(make_request(8'h63, 1'b1, 1'b1));
        // single extreme bytes carrying the end mark
        send_request(make_request(8'h00, 1'b1, 1'b1));
        send_request(make_request(8'hFF, 1'b1, 1'b1));
        // bytes, then a byteless end mark
        send_request(make_request(8'h80, 1'b1, 1'b0));
        send_request(make_request(8'h7F, 1'b1, 1'b0));
        send_request(make_request(8'h55, 1'b0, 1'b1));
        // ignored request inside a message
        send_request(make_request(8'h01, 1'b1, 1'b0));
        send_request(make_request(8'hAA, 1'b0, 1'b0));
        send_request(make_request(8'hFE, 1'b1, 1'b1));

        while (requests_sent < TOTAL_REQUESTS)
        begin
            // trim the last message so the total stays near the target
            len = pick_length();
            if (len > TOTAL_REQUESTS - requests_sent)
                len = TOTAL_REQUESTS - requests_sent;
            send_message(len);
        end

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
